// ----- rtl/core/gmdfs_pkg.sv -----
// shared types and constants of the grid maze depth-first search block
`default_nettype none

package gmdfs_pkg;

  // cell codes held in the grid memory
  localparam logic [1:0] KIND_BLOCKED = 2'd0;
  localparam logic [1:0] KIND_OPEN    = 2'd1;
  localparam logic [1:0] KIND_TARGET  = 2'd2;
  localparam logic [1:0] KIND_VISITED = 2'd3;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 1'b1;

  // neighbor order of the search
  typedef enum logic [1:0] {
    DIR_UP,
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT
  } dir_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;    // input beat accepted, cell written
    logic start;   // seed the stack with the start cell
    logic probe;   // step the top entry, read its neighbor
    logic check;   // act on the neighbor's content
    logic finish;  // move the answer into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic start_in;    // start cell lies inside the grid
    logic search_end;  // target hit or stack ran empty
    logic out_free;    // output register can take a result
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/grid_maze_depth_first_search.sv -----
// top level of the grid maze depth-first search block
//
//   port group   direction  beat contents              handshake
//   in           in         cell_kind, last_cell       in_valid_i / in_stall_o
//   out          out        found, found_row, found_col out_valid_o / out_stall_i
//   cfg          in         start_row, start_col       cfg_we_i, cfg_idx_i, cfg_data_i
//
// cells load at one beat per cycle into the grid memory, row-major, while in_stall_o is low
// the beat with last_cell set starts a search: a start state seeds the stack, then
// each neighbor tried takes a probe state (registered read of the grid memory) and a
// check state, and a finish state posts the result
// the input stalls from the last cell until the result sits in the output register
// reset clears the control state only; grid and stack contents stay undefined
`default_nettype none

module grid_maze_depth_first_search #(
  parameter int GRID_SIZE = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [gmdfs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        cell_kind_i,
  input  logic                              last_cell_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [3:0]                        found_row_o,
  output logic [3:0]                        found_col_o
);
  import gmdfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  gmdfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .last_cell_i (last_cell_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and search registers
  gmdfs_datapath #(
    .GRID_SIZE (GRID_SIZE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cell_kind_i (cell_kind_i),
    .last_cell_i (last_cell_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .found_o     (found_o),
    .found_row_o (found_row_o),
    .found_col_o (found_col_o)
  );

  // at most one datapath command per cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.start, cmd.probe, cmd.check, cmd.finish}))
    else $error("more than one datapath command in a cycle");

  // the last cell beat launches the search next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load && last_cell_i |=> cmd.start && in_stall_o)
    else $error("search did not start after the last cell");

  // every neighbor probe is followed by its check
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.probe |=> cmd.check)
    else $error("probe not followed by check");

  // a posted result shows up as a valid output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_valid_o && !in_stall_o)
    else $error("finished search did not post a result");

endmodule

`default_nettype wire

// ----- rtl/core/gmdfs_ctrl.sv -----
// controller state machine of the grid maze search
`default_nettype none

module gmdfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              last_cell_i,
  input  gmdfs_pkg::sts_t   sts_i,
  output gmdfs_pkg::cmd_t   cmd_o
);
  import gmdfs_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_PROBE,
    ST_CHECK,
    ST_FINISH
  } state_e;

  state_e state_q;

  // commands decoded from the state
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == ST_LOAD) && in_valid_i;
    cmd_o.start  = (state_q == ST_START);
    cmd_o.probe  = (state_q == ST_PROBE);
    cmd_o.check  = (state_q == ST_CHECK);
    cmd_o.finish = (state_q == ST_FINISH) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != ST_LOAD);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i && last_cell_i) state_q <= ST_START;
        end
        ST_START: begin
          state_q <= sts_i.start_in ? ST_PROBE : ST_FINISH;
        end
        ST_PROBE: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          state_q <= sts_i.search_end ? ST_FINISH : ST_PROBE;
        end
        ST_FINISH: begin
          if (sts_i.out_free) state_q <= ST_LOAD;
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gmdfs_datapath.sv -----
// grid memory, path stack, search registers and result register
`default_nettype none

module gmdfs_datapath #(
  parameter int GRID_SIZE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gmdfs_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [1:0]                          cell_kind_i,
  input  logic                                last_cell_i,
  input  gmdfs_pkg::cmd_t                     cmd_i,
  output gmdfs_pkg::sts_t                     sts_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output logic                                found_o,
  output logic [3:0]                          found_row_o,
  output logic [3:0]                          found_col_o
);
  import gmdfs_pkg::*;

  localparam int CellCount = GRID_SIZE * GRID_SIZE;
  localparam int CW = $clog2(GRID_SIZE);
  localparam int AW = $clog2(CellCount);
  localparam logic [CW-1:0] LastCoord = CW'(GRID_SIZE - 1);
  localparam logic [AW-1:0] LastAddr  = AW'(CellCount - 1);
  localparam logic [AW-1:0] RowPitch  = AW'(GRID_SIZE);
  localparam logic [AW:0]   DepthMax  = (AW + 1)'(CellCount);

  typedef struct packed {
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    dir_e          dir;
  } entry_t;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                              input logic [CW-1:0] col);
    return AW'(row) * RowPitch + AW'(col);
  endfunction

  // storage
  logic [1:0] grid_mem [CellCount];
  entry_t     stk_mem  [CellCount];
  logic [1:0] grid_rd_q;
  entry_t     stk_rd_q;

  // control registers
  logic [AW-1:0]         load_pos_q;
  logic [AW:0]           depth_q;
  logic [CFG_DATA_W-1:0] start_row_q;
  logic [CFG_DATA_W-1:0] start_col_q;
  logic                  hit_q;
  logic                  out_valid_q;

  // payload registers
  logic [CW-1:0] top_row_q, top_col_q;
  dir_e          top_dir_q;
  logic [CW-1:0] nb_row_q, nb_col_q;
  logic          nb_ok_q;
  logic          popped_q;
  logic [CW-1:0] hit_row_q, hit_col_q;
  logic          out_found_q;
  logic [3:0]    out_row_q, out_col_q;

  logic [CW-1:0] nb_row_d, nb_col_d;
  logic          nb_ok_d;
  logic          start_in;
  logic [CW-1:0] start_r, start_c;
  logic          hit_now, push, is_left;
  logic          grid_we;
  logic [AW-1:0] grid_wa;
  logic [1:0]    grid_wd;

  assign start_in = (32'(start_row_q) < GRID_SIZE) && (32'(start_col_q) < GRID_SIZE);
  assign start_r  = CW'(start_row_q);
  assign start_c  = CW'(start_col_q);
  assign is_left  = (top_dir_q == DIR_LEFT);

  // neighbor of the top entry in its current direction
  always_comb begin
    nb_ok_d  = 1'b0;
    nb_row_d = top_row_q;
    nb_col_d = top_col_q;
    case (top_dir_q)
      DIR_UP: begin
        if (top_row_q != '0) begin
          nb_ok_d  = 1'b1;
          nb_row_d = top_row_q - CW'(1);
        end
      end
      DIR_RIGHT: begin
        if (top_col_q != LastCoord) begin
          nb_ok_d  = 1'b1;
          nb_col_d = top_col_q + CW'(1);
        end
      end
      DIR_DOWN: begin
        if (top_row_q != LastCoord) begin
          nb_ok_d  = 1'b1;
          nb_row_d = top_row_q + CW'(1);
        end
      end
      DIR_LEFT: begin
        if (top_col_q != '0) begin
          nb_ok_d  = 1'b1;
          nb_col_d = top_col_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // decision on the neighbor's content
  assign hit_now = nb_ok_q && (grid_rd_q == KIND_TARGET);
  assign push    = nb_ok_q && (grid_rd_q == KIND_OPEN) && (depth_q < DepthMax);

  assign sts_o.start_in   = start_in;
  assign sts_o.search_end = hit_now || (!push && (depth_q == '0));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // grid write port: cell loads and visited marks
  always_comb begin
    grid_we = 1'b0;
    grid_wa = load_pos_q;
    grid_wd = cell_kind_i;
    if (cmd_i.load) begin
      grid_we = 1'b1;
    end else if (cmd_i.start && start_in) begin
      grid_we = 1'b1;
      grid_wa = cell_addr(start_r, start_c);
      grid_wd = KIND_VISITED;
    end else if (cmd_i.check && push) begin
      grid_we = 1'b1;
      grid_wa = cell_addr(nb_row_q, nb_col_q);
      grid_wd = KIND_VISITED;
    end
  end

  // grid memory
  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_wa] <= grid_wd;
    if (cmd_i.probe) grid_rd_q <= grid_mem[cell_addr(nb_row_d, nb_col_d)];
  end

  // stack memory holds the entries below the top register
  always_ff @(posedge clk_i) begin
    if (cmd_i.check && push && !popped_q) begin
      stk_mem[AW'(depth_q - (AW + 1)'(1))] <= '{row: top_row_q, col: top_col_q, dir: top_dir_q};
    end
    if (cmd_i.probe && is_left && (depth_q > (AW + 1)'(1))) begin
      stk_rd_q <= stk_mem[AW'(depth_q - (AW + 1)'(2))];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q  <= '0;
      depth_q     <= '0;
      start_row_q <= '0;
      start_col_q <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_ROW: start_row_q <= cfg_data_i;
          REG_START_COL: start_col_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        if (last_cell_i || (load_pos_q == LastAddr)) load_pos_q <= '0;
        else load_pos_q <= load_pos_q + AW'(1);
      end
      if (cmd_i.start) begin
        depth_q <= start_in ? (AW + 1)'(1) : '0;
        hit_q   <= 1'b0;
      end else if (cmd_i.probe && is_left) begin
        depth_q <= depth_q - (AW + 1)'(1);
      end else if (cmd_i.check) begin
        if (hit_now) hit_q <= 1'b1;
        else if (push) depth_q <= depth_q + (AW + 1)'(1);
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // search and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      top_row_q <= start_r;
      top_col_q <= start_c;
      top_dir_q <= DIR_UP;
      hit_row_q <= '0;
      hit_col_q <= '0;
    end
    if (cmd_i.probe) begin
      nb_row_q <= nb_row_d;
      nb_col_q <= nb_col_d;
      nb_ok_q  <= nb_ok_d;
      popped_q <= is_left;
      if (!is_left) top_dir_q <= dir_e'(top_dir_q + 2'd1);
    end
    if (cmd_i.check) begin
      if (hit_now) begin
        hit_row_q <= nb_row_q;
        hit_col_q <= nb_col_q;
      end else if (push) begin
        top_row_q <= nb_row_q;
        top_col_q <= nb_col_q;
        top_dir_q <= DIR_UP;
      end else if (popped_q && (depth_q != '0)) begin
        top_row_q <= stk_rd_q.row;
        top_col_q <= stk_rd_q.col;
        top_dir_q <= stk_rd_q.dir;
      end
    end
    if (cmd_i.finish) begin
      out_found_q <= hit_q;
      out_row_q   <= 4'(hit_row_q);
      out_col_q   <= 4'(hit_col_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = out_found_q;
  assign found_row_o = out_row_q;
  assign found_col_o = out_col_q;

endmodule

`default_nettype wire
